// ===== design/waypoint_kinematics_estimator_macros.svh =====
// ----------------------------------------------------------------------------
// Waypoint kinematics estimator assertion macros
// Property wrappers used by the asserting RTL file.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_KINEMATICS_ESTIMATOR_MACROS_SVH
`define WAYPOINT_KINEMATICS_ESTIMATOR_MACROS_SVH

// Same-cycle implication
`define WKE_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define WKE_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/wke_pkg.sv =====
// ----------------------------------------------------------------------------
// Waypoint kinematics estimator package
// Shared constants, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package wke_pkg;

	// pi/2 in Q16.16
	localparam logic [16:0] HALF_PI_Q16 = 17'd102944;

	// Register indexes of the configuration port
	typedef enum logic [3:0] {
		CFG_STEP_TIME   = 4'd0,
		CFG_WHEEL_BASE  = 4'd1,
		CFG_SPEED_LIMIT = 4'd2,
		CFG_STEER_LIMIT = 4'd3,
		CFG_ACCEL_UPPER = 4'd4,
		CFG_ACCEL_LOWER = 4'd5,
		CFG_SRATE_LIMIT = 4'd6,
		CFG_JERK_LIMIT  = 4'd7
	} cfg_idx_t;

	// atan(2^-i) in Q2.30
	function automatic logic [29:0] cordic_angle(input logic [4:0] i);
		logic [29:0] a;
		case (i)
			5'd0:    a = 30'd843314857;
			5'd1:    a = 30'd497837829;
			5'd2:    a = 30'd263043837;
			5'd3:    a = 30'd133525159;
			5'd4:    a = 30'd67021687;
			5'd5:    a = 30'd33543516;
			5'd6:    a = 30'd16775851;
			5'd7:    a = 30'd8388437;
			5'd8:    a = 30'd4194283;
			5'd9:    a = 30'd2097149;
			5'd10:   a = 30'd1048576;
			5'd11:   a = 30'd524288;
			default: a = 30'(30'd1 << (5'd30 - i));
		endcase
		return a;
	endfunction

endpackage

// ===== design/wke_div.sv =====
// ----------------------------------------------------------------------------
// Waypoint kinematics estimator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wke_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [48:0] dividend,
	input  logic [30:0] divisor,
	output logic        done,
	output logic [48:0] quotient
);
	import wke_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [30:0] rem_q;
	logic [48:0] quo_q;
	logic [31:0] trial;
	logic        fits;

	// Bring down the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[48]};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? 31'(trial - {1'b0, divisor}) : trial[30:0];
			quo_q <= {quo_q[47:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== design/wke_sqrt.sv =====
// ----------------------------------------------------------------------------
// Waypoint kinematics estimator square root
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module wke_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] radicand,
	output logic        done,
	output logic [32:0] root
);
	import wke_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [65:0] rad_q;
	logic [32:0] root_q;
	logic [34:0] rem_q;
	logic [36:0] work;
	logic [34:0] trial;
	logic        fits;

	// Append the next bit pair and compare against 4*root+1
	assign work  = {rem_q, rad_q[65:64]};
	assign trial = {root_q[32:0], 2'b01};
	assign fits  = (work >= {2'b00, trial});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// Root and remainder datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[63:0], 2'b00};
			root_q <= {root_q[31:0], fits};
			rem_q  <= fits ? 35'(work - {2'b00, trial}) : work[34:0];
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== design/wke_cordic.sv =====
// ----------------------------------------------------------------------------
// Waypoint kinematics estimator CORDIC
// Vectoring-mode arctangent of y/x for nonnegative operands, one
// micro-rotation per cycle after a range reduction shift.
// ----------------------------------------------------------------------------
module wke_cordic (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] y_in,
	input  logic [61:0] x_in,
	output logic        done,
	output logic [16:0] angle
);
	import wke_pkg::*;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_NORM,
		CS_ROT,
		CS_FIN
	} cordic_state_t;

	cordic_state_t      state_q;
	logic               done_q;
	logic [4:0]         iter_q;
	logic [63:0]        yu_q;
	logic [61:0]        xu_q;
	logic signed [43:0] x_q;
	logic signed [43:0] y_q;
	logic signed [32:0] z_q;
	logic [16:0]        angle_q;

	logic signed [43:0] tx;
	logic signed [43:0] ty;
	logic signed [32:0] a_ext;
	logic signed [32:0] z_rnd;
	logic signed [18:0] r;

	assign tx    = x_q >>> iter_q;
	assign ty    = y_q >>> iter_q;
	assign a_ext = $signed({3'b000, cordic_angle(iter_q)});
	assign z_rnd = z_q + 33'sd8192;
	assign r     = 19'(z_rnd >>> 14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			done_q  <= 1'b0;
			iter_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				CS_IDLE: begin
					if (start) begin
						state_q <= CS_NORM;
					end
				end
				CS_NORM: begin
					iter_q <= '0;
					if ((yu_q[63:40] == '0) && (xu_q[61:40] == '0)) begin
						state_q <= CS_ROT;
					end
				end
				CS_ROT: begin
					if (iter_q == 5'd29) begin
						state_q <= CS_FIN;
					end else begin
						iter_q <= iter_q + 5'd1;
					end
				end
				CS_FIN: begin
					done_q  <= 1'b1;
					state_q <= CS_IDLE;
				end
				default: state_q <= CS_IDLE;
			endcase
		end
	end

	// Operand shift, rotation and angle accumulation
	always_ff @(posedge clk) begin
		if (start && (state_q == CS_IDLE)) begin
			yu_q <= y_in;
			xu_q <= x_in;
		end else if (state_q == CS_NORM) begin
			if ((yu_q[63:40] == '0) && (xu_q[61:40] == '0)) begin
				x_q <= $signed({4'b0000, xu_q[39:0]});
				y_q <= $signed({4'b0000, yu_q[39:0]});
				z_q <= '0;
			end else begin
				yu_q <= yu_q >> 1;
				xu_q <= xu_q >> 1;
			end
		end else if (state_q == CS_ROT) begin
			if (!y_q[43]) begin
				x_q <= x_q + ty;
				y_q <= y_q - tx;
				z_q <= z_q + a_ext;
			end else begin
				x_q <= x_q - ty;
				y_q <= y_q + tx;
				z_q <= z_q - a_ext;
			end
		end else if (state_q == CS_FIN) begin
			// Round to Q16.16 and limit to [0, pi/2]
			if (r < 0) begin
				angle_q <= '0;
			end else if (r > $signed({2'b00, HALF_PI_Q16})) begin
				angle_q <= HALF_PI_Q16;
			end else begin
				angle_q <= r[16:0];
			end
		end
	end

	assign done  = done_q;
	assign angle = angle_q;
endmodule

// ===== design/waypoint_kinematics_estimator.sv =====
// ----------------------------------------------------------------------------
// Waypoint kinematics estimator
// Derives speed, steering, acceleration, steering rate and jerk from a
// stream of Q16.16 waypoints by finite differences.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration writes go over cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write only while the block is idle.
//   Waypoints enter over in_valid/in_ready; each transaction yields one
//   result transaction on out_valid/out_ready.
//   A first_point waypoint goes straight to the final step and returns
//   all zeros. Others pass through a shared 33x33 multiplier, a 33-step
//   square root, up to 24 shift and 30 rotation steps when the CORDIC runs
//   and four 49-step divisions by the step time; in_ready is high only
//   while idle, so a new waypoint is taken only once the last one is through.
//   The result sits in an output register; the next waypoint is taken
//   while it waits, and a stalled receiver only holds the sequencer at its
//   final step until the previous result is taken.
//   Reset loads the default register values and clears the waypoint and
//   derived-value history to zero.
// ----------------------------------------------------------------------------
`include "waypoint_kinematics_estimator_macros.svh"

module waypoint_kinematics_estimator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] heading,
	input  logic               first_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [30:0]        speed,
	output logic signed [31:0] steer,
	output logic signed [31:0] accel,
	output logic signed [31:0] steer_rate,
	output logic signed [31:0] jerk
);
	import wke_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_RT_GO,
		ST_RT_WAIT,
		ST_SPD_GO,
		ST_SPD_WAIT,
		ST_NUM,
		ST_DEN,
		ST_AT_GO,
		ST_AT_WAIT,
		ST_STR,
		ST_ACC_GO,
		ST_ACC_WAIT,
		ST_SR_GO,
		ST_SR_WAIT,
		ST_JK_GO,
		ST_JK_WAIT,
		ST_DONE
	} state_t;

	// Configuration registers
	logic [30:0]        step_time_q;
	logic [30:0]        wheel_base_q;
	logic [30:0]        speed_limit_q;
	logic [30:0]        steer_limit_q;
	logic signed [31:0] accel_upper_q;
	logic signed [31:0] accel_lower_q;
	logic [30:0]        srate_limit_q;
	logic [30:0]        jerk_limit_q;

	// History
	logic signed [31:0] prev_x_q;
	logic signed [31:0] prev_y_q;
	logic signed [31:0] prev_heading_q;
	logic [30:0]        prev_speed_q;
	logic signed [31:0] prev_steer_q;
	logic signed [31:0] prev_accel_q;

	// Working registers
	state_t             state_q;
	logic [32:0]        ax_q;
	logic [32:0]        ay_q;
	logic [32:0]        adh_q;
	logic               dh_neg_q;
	logic [65:0]        prod_q;
	logic [65:0]        sqx_q;
	logic [63:0]        num_q;
	logic [16:0]        steer_mag_q;
	logic               div_neg_q;
	logic [30:0]        speed_q;
	logic signed [31:0] steer_q;
	logic signed [31:0] accel_q;
	logic signed [31:0] srate_q;
	logic signed [31:0] jerk_q;

	// Output registers
	logic               out_valid_q;
	logic [30:0]        speed_out_q;
	logic signed [31:0] steer_out_q;
	logic signed [31:0] accel_out_q;
	logic signed [31:0] srate_out_q;
	logic signed [31:0] jerk_out_q;

	// Combinational signals
	logic [30:0]        h;
	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic signed [32:0] dh;
	logic [32:0]        mul_a;
	logic [32:0]        mul_b;
	logic signed [32:0] diff;
	logic [32:0]        diff_mag;
	logic               sqrt_start;
	logic               sqrt_done;
	logic [32:0]        sqrt_root;
	logic               div_start;
	logic [48:0]        div_dividend;
	logic               div_done;
	logic [48:0]        div_quo;
	logic               cordic_start;
	logic               cordic_done;
	logic [16:0]        cordic_angle_out;
	logic signed [49:0] rate_s;
	logic signed [49:0] acc_c;
	logic signed [49:0] steer_s;
	logic               in_fire;

	function automatic logic [32:0] abs33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic signed [31:0] clamp_sym(input logic signed [49:0] v,
			input logic [30:0] lim);
		logic signed [49:0] l;
		logic signed [49:0] r;
		l = $signed({19'b0, lim});
		r = v;
		if (r < -l) begin
			r = -l;
		end
		if (r > l) begin
			r = l;
		end
		return r[31:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;

	// Zero step time acts as one LSB
	assign h = (step_time_q == '0) ? 31'd1 : step_time_q;

	// Differences against the stored waypoint
	assign dx = $signed({pos_x[31], pos_x}) - $signed({prev_x_q[31], prev_x_q});
	assign dy = $signed({pos_y[31], pos_y}) - $signed({prev_y_q[31], prev_y_q});
	assign dh = $signed({heading[31], heading})
		- $signed({prev_heading_q[31], prev_heading_q});

	// Multiplier operand select
	always_comb begin
		case (state_q)
			ST_SQX: begin
				mul_a = ax_q;
				mul_b = ax_q;
			end
			ST_SQY: begin
				mul_a = ay_q;
				mul_b = ay_q;
			end
			ST_NUM: begin
				mul_a = adh_q;
				mul_b = {2'b00, wheel_base_q};
			end
			ST_DEN: begin
				mul_a = {2'b00, speed_q};
				mul_b = {2'b00, h};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Rate difference select
	always_comb begin
		case (state_q)
			ST_ACC_GO: diff = $signed({2'b00, speed_q}) - $signed({2'b00, prev_speed_q});
			ST_SR_GO:  diff = $signed({steer_q[31], steer_q})
				- $signed({prev_steer_q[31], prev_steer_q});
			ST_JK_GO:  diff = $signed({accel_q[31], accel_q})
				- $signed({prev_accel_q[31], prev_accel_q});
			default:   diff = '0;
		endcase
	end
	assign diff_mag = abs33(diff);

	// Unit starts and divider operand
	assign sqrt_start   = (state_q == ST_RT_GO);
	assign cordic_start = (state_q == ST_AT_GO) && (num_q != '0) && (prod_q[61:0] != '0);
	assign div_start    = (state_q == ST_SPD_GO) || (state_q == ST_ACC_GO)
		|| (state_q == ST_SR_GO) || (state_q == ST_JK_GO);
	assign div_dividend = (state_q == ST_SPD_GO) ? {sqrt_root, 16'b0} : {diff_mag, 16'b0};

	// Signed quotient and clamps
	assign rate_s  = div_neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign steer_s = dh_neg_q ? -$signed({33'b0, steer_mag_q}) : $signed({33'b0, steer_mag_q});
	always_comb begin
		acc_c = rate_s;
		if (acc_c < $signed({{18{accel_lower_q[31]}}, accel_lower_q})) begin
			acc_c = $signed({{18{accel_lower_q[31]}}, accel_lower_q});
		end
		if (acc_c > $signed({{18{accel_upper_q[31]}}, accel_upper_q})) begin
			acc_c = $signed({{18{accel_upper_q[31]}}, accel_upper_q});
		end
	end

	wke_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (66'(sqx_q + prod_q)),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	wke_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (h),
		.done     (div_done),
		.quotient (div_quo)
	);

	wke_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.y_in   (num_q),
		.x_in   (prod_q[61:0]),
		.done   (cordic_done),
		.angle  (cordic_angle_out)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q   <= 31'd1638;
			wheel_base_q  <= 31'd183501;
			speed_limit_q <= 31'd655360;
			steer_limit_q <= 31'd45875;
			accel_upper_q <= 32'sd131072;
			accel_lower_q <= -32'sd131072;
			srate_limit_q <= 31'd32768;
			jerk_limit_q  <= 31'd196608;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STEP_TIME:   step_time_q   <= cfg_data[30:0];
				CFG_WHEEL_BASE:  wheel_base_q  <= cfg_data[30:0];
				CFG_SPEED_LIMIT: speed_limit_q <= cfg_data[30:0];
				CFG_STEER_LIMIT: steer_limit_q <= cfg_data[30:0];
				CFG_ACCEL_UPPER: accel_upper_q <= cfg_data;
				CFG_ACCEL_LOWER: accel_lower_q <= cfg_data;
				CFG_SRATE_LIMIT: srate_limit_q <= cfg_data[30:0];
				CFG_JERK_LIMIT:  jerk_limit_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Sequencer, history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			prev_heading_q <= '0;
			prev_speed_q   <= '0;
			prev_steer_q   <= '0;
			prev_accel_q   <= '0;
		end else begin
			// Drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			prod_q <= mul_a * mul_b;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						ax_q           <= abs33(dx);
						ay_q           <= abs33(dy);
						adh_q          <= abs33(dh);
						dh_neg_q       <= dh[32];
						prev_x_q       <= pos_x;
						prev_y_q       <= pos_y;
						prev_heading_q <= heading;
						if (first_point) begin
							speed_q <= '0;
							steer_q <= '0;
							accel_q <= '0;
							srate_q <= '0;
							jerk_q  <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SQX;
						end
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: begin
					sqx_q   <= prod_q;
					state_q <= ST_RT_GO;
				end
				ST_RT_GO: state_q <= ST_RT_WAIT;
				ST_RT_WAIT: begin
					if (sqrt_done) begin
						state_q <= ST_SPD_GO;
					end
				end
				ST_SPD_GO: state_q <= ST_SPD_WAIT;
				ST_SPD_WAIT: begin
					if (div_done) begin
						speed_q <= (div_quo > {18'b0, speed_limit_q}) ? speed_limit_q
							: div_quo[30:0];
						state_q <= ST_NUM;
					end
				end
				ST_NUM: state_q <= ST_DEN;
				ST_DEN: begin
					num_q   <= prod_q[63:0];
					state_q <= ST_AT_GO;
				end
				ST_AT_GO: begin
					// Zero numerator or zero denominator skip the CORDIC
					if (num_q == '0) begin
						steer_mag_q <= '0;
						state_q     <= ST_STR;
					end else if (prod_q[61:0] == '0) begin
						steer_mag_q <= HALF_PI_Q16;
						state_q     <= ST_STR;
					end else begin
						state_q <= ST_AT_WAIT;
					end
				end
				ST_AT_WAIT: begin
					if (cordic_done) begin
						steer_mag_q <= cordic_angle_out;
						state_q     <= ST_STR;
					end
				end
				ST_STR: begin
					steer_q <= clamp_sym(steer_s, steer_limit_q);
					state_q <= ST_ACC_GO;
				end
				ST_ACC_GO: begin
					div_neg_q <= diff[32];
					state_q   <= ST_ACC_WAIT;
				end
				ST_ACC_WAIT: begin
					if (div_done) begin
						accel_q <= acc_c[31:0];
						state_q <= ST_SR_GO;
					end
				end
				ST_SR_GO: begin
					div_neg_q <= diff[32];
					state_q   <= ST_SR_WAIT;
				end
				ST_SR_WAIT: begin
					if (div_done) begin
						srate_q <= clamp_sym(rate_s, srate_limit_q);
						state_q <= ST_JK_GO;
					end
				end
				ST_JK_GO: begin
					div_neg_q <= diff[32];
					state_q   <= ST_JK_WAIT;
				end
				ST_JK_WAIT: begin
					if (div_done) begin
						jerk_q  <= clamp_sym(rate_s, jerk_limit_q);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						speed_out_q  <= speed_q;
						steer_out_q  <= steer_q;
						accel_out_q  <= accel_q;
						srate_out_q  <= srate_q;
						jerk_out_q   <= jerk_q;
						prev_speed_q <= speed_q;
						prev_steer_q <= steer_q;
						prev_accel_q <= accel_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign speed      = speed_out_q;
	assign steer      = steer_out_q;
	assign accel      = accel_out_q;
	assign steer_rate = srate_out_q;
	assign jerk       = jerk_out_q;

	// A taken waypoint leaves the sequencer busy in the cycle after acceptance
	`WKE_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready, "ready high after accept")
	// Steering never leaves the quarter turn
	`WKE_ASSERT_IMP(a_steer_range, out_valid, (steer <= 32'sd102944) && (steer >= -32'sd102944), "steer out of range")
	// A new result never overwrites one that is still waiting
	`WKE_ASSERT_NXT(a_no_overwrite, out_valid && !out_ready, $stable(speed) && $stable(jerk), "result overwritten while stalled")

endmodule

// ===== verif/waypoint_kinematics_estimator_test.sv =====
// ----------------------------------------------------------------------------
// Waypoint kinematics estimator testbench
// Drives waypoint trajectories through the block under several register
// settings and checks every derived value against a cycle-free predictor.
// Both handshakes are throttled at random, and a scoreboard of expected
// kinematics is checked in order.
// ----------------------------------------------------------------------------
module waypoint_kinematics_estimator_test;
	import wke_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_POINTS = 500;

	typedef struct {
		logic [30:0]        speed;
		logic signed [31:0] steer;
		logic signed [31:0] accel;
		logic signed [31:0] steer_rate;
		logic signed [31:0] jerk;
	} kinematics_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [3:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] heading = '0;
	logic               first_point = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [30:0]        speed;
	logic signed [31:0] steer;
	logic signed [31:0] accel;
	logic signed [31:0] steer_rate;
	logic signed [31:0] jerk;

	// Predictor registers and history
	logic [30:0]        step_time_q, wheel_base_q, speed_limit_q, steer_limit_q;
	logic signed [31:0] accel_upper_q, accel_lower_q;
	logic [30:0]        srate_limit_q, jerk_limit_q;
	logic signed [31:0] last_x, last_y, last_heading;
	longint             last_speed, last_steer, last_accel;

	kinematics_t expected_kin[$];
	int          error_count = 0;
	int          points_sent = 0;
	int          results_seen = 0;
	int          config_writes = 0;
	longint      cycle_count = 0;
	int          stall_left = 0;

	waypoint_kinematics_estimator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading), .first_point(first_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.speed(speed), .steer(steer), .accel(accel),
		.steer_rate(steer_rate), .jerk(jerk)
	);

	always #10 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 6);
		return $urandom_range(20, 500);
	endfunction

	// Throttle the receiver, with quiet stretches of no stall
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		kinematics_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_kin.size() == 0) begin
				$error("result with no waypoint outstanding");
				error_count++;
			end else begin
				e = expected_kin.pop_front();
				if (speed !== e.speed) begin
					$error("speed expected %0d got %0d", e.speed, speed);
					error_count++;
				end
				if (steer !== e.steer) begin
					$error("steer expected %0d got %0d", e.steer, steer);
					error_count++;
				end
				if (accel !== e.accel) begin
					$error("accel expected %0d got %0d", e.accel, accel);
					error_count++;
				end
				if (steer_rate !== e.steer_rate) begin
					$error("steer_rate expected %0d got %0d", e.steer_rate, steer_rate);
					error_count++;
				end
				if (jerk !== e.jerk) begin
					$error("jerk expected %0d got %0d", e.jerk, jerk);
					error_count++;
				end
			end
		end
	end

	function automatic void load_defaults();
		step_time_q = 31'd1638;
		wheel_base_q = 31'd183501;
		speed_limit_q = 31'd655360;
		steer_limit_q = 31'd45875;
		accel_upper_q = 32'sd131072;
		accel_lower_q = -32'sd131072;
		srate_limit_q = 31'd32768;
		jerk_limit_q = 31'd196608;
		last_x = '0;
		last_y = '0;
		last_heading = '0;
		last_speed = 0;
		last_steer = 0;
		last_accel = 0;
	endfunction

	function automatic void apply_register(cfg_idx_t idx, logic [31:0] data);
		case (idx)
			CFG_STEP_TIME:   step_time_q = data[30:0];
			CFG_WHEEL_BASE:  wheel_base_q = data[30:0];
			CFG_SPEED_LIMIT: speed_limit_q = data[30:0];
			CFG_STEER_LIMIT: steer_limit_q = data[30:0];
			CFG_ACCEL_UPPER: accel_upper_q = data;
			CFG_ACCEL_LOWER: accel_lower_q = data;
			CFG_SRATE_LIMIT: srate_limit_q = data[30:0];
			CFG_JERK_LIMIT:  jerk_limit_q = data[30:0];
			default: ;
		endcase
	endfunction

	// Floor of the square root of a 66-bit sum of squares
	function automatic longint floor_sqrt(logic [65:0] val);
		logic [67:0] rem, trial;
		logic [33:0] root;
		rem = '0;
		root = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | 68'(val[2*i +: 2]);
			trial = 68'({root, 2'b01});
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[32:0], 1'b1};
			end else begin
				root = {root[32:0], 1'b0};
			end
		end
		return longint'(root);
	endfunction

	// Vectoring CORDIC, returns atan(num/den) in Q16.16 limited to [0, pi/2]
	function automatic longint steer_angle(logic [63:0] num, logic [63:0] den);
		longint cx, cy, angle, tx, ty, r;
		while (((num | den) >> 40) != 0) begin
			num = num >> 1;
			den = den >> 1;
		end
		cx = longint'(den);
		cy = longint'(num);
		angle = 0;
		for (int i = 0; i < 30; i++) begin
			ty = cy >>> i;
			tx = cx >>> i;
			if (cy >= 0) begin
				cx += ty; cy -= tx; angle += longint'(cordic_angle(5'(i)));
			end else begin
				cx -= ty; cy += tx; angle -= longint'(cordic_angle(5'(i)));
			end
		end
		r = (angle + 8192) >>> 14;
		if (r < 0) r = 0;
		if (r > longint'(HALF_PI_Q16)) r = longint'(HALF_PI_Q16);
		return r;
	endfunction

	// Difference over one step, truncated toward zero
	function automatic longint per_step(longint diff, longint h);
		longint q;
		q = ((diff < 0 ? -diff : diff) << 16) / h;
		return diff < 0 ? -q : q;
	endfunction

	function automatic longint limit_sym(longint v, logic [30:0] lim);
		longint l;
		l = longint'(lim);
		if (v < -l) v = -l;
		if (v > l) v = l;
		return v;
	endfunction

	// Derive the kinematics of one waypoint and advance the history
	function automatic kinematics_t derive_kinematics(logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] hd, logic first);
		kinematics_t k;
		longint h, dx, dy, dh, sp, st, ac, sr, jk, path_len;
		logic [65:0] sumsq, ax, ay;
		logic [63:0] num, den;
		sp = 0; st = 0; ac = 0; sr = 0; jk = 0;
		if (!first) begin
			h = step_time_q == 0 ? 1 : longint'(step_time_q);
			dx = longint'(x) - longint'(last_x);
			dy = longint'(y) - longint'(last_y);
			dh = longint'(hd) - longint'(last_heading);
			ax = 66'(dx < 0 ? -dx : dx);
			ay = 66'(dy < 0 ? -dy : dy);
			sumsq = ax * ax + ay * ay;
			path_len = floor_sqrt(sumsq);
			sp = (path_len << 16) / h;
			if (sp > longint'(speed_limit_q)) sp = longint'(speed_limit_q);
			num = 64'(dh < 0 ? -dh : dh) * 64'(wheel_base_q);
			den = 64'(sp) * 64'(h);
			if (num == 0) st = 0;
			else if (den == 0) st = longint'(HALF_PI_Q16);
			else st = steer_angle(num, den);
			if (dh < 0) st = -st;
			st = limit_sym(st, steer_limit_q);
			ac = per_step(sp - last_speed, h);
			if (ac < longint'(accel_lower_q)) ac = longint'(accel_lower_q);
			if (ac > longint'(accel_upper_q)) ac = longint'(accel_upper_q);
			sr = limit_sym(per_step(st - last_steer, h), srate_limit_q);
			jk = limit_sym(per_step(ac - last_accel, h), jerk_limit_q);
		end
		last_x = x;
		last_y = y;
		last_heading = hd;
		last_speed = sp;
		last_steer = st;
		last_accel = ac;
		k.speed = sp[30:0];
		k.steer = st[31:0];
		k.accel = ac[31:0];
		k.steer_rate = sr[31:0];
		k.jerk = jk[31:0];
		return k;
	endfunction

	// Send one waypoint; starts and ends on a falling edge
	task automatic send_waypoint(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] hd, logic first);
		int gap;
		pos_x <= x;
		pos_y <= y;
		heading <= hd;
		first_point <= first;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_kin = {expected_kin, derive_kinematics(x, y, hd, first)};
		points_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Hold until every expected result is back and the sequencer settles
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_kin.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_register(logic [3:0] idx, logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_register(cfg_idx_t'(idx), data);
		config_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all(logic [31:0] st, logic [31:0] wb, logic [31:0] sl,
			logic [31:0] stl, logic [31:0] au, logic [31:0] al,
			logic [31:0] srl, logic [31:0] jl);
		drain();
		write_register(CFG_STEP_TIME, st);
		write_register(CFG_WHEEL_BASE, wb);
		write_register(CFG_SPEED_LIMIT, sl);
		write_register(CFG_STEER_LIMIT, stl);
		write_register(CFG_ACCEL_UPPER, au);
		write_register(CFG_ACCEL_LOWER, al);
		write_register(CFG_SRATE_LIMIT, srl);
		write_register(CFG_JERK_LIMIT, jl);
	endtask

	// Short trajectory with modest increments
	task automatic send_track(int n, int step_mag, int turn_mag);
		logic signed [31:0] x, y, hd;
		x = $urandom();
		y = $urandom();
		hd = $urandom_range(0, 400000);
		send_waypoint(x, y, hd, 1'b1);
		for (int i = 1; i < n; i++) begin
			x = x + ($urandom_range(0, 2 * step_mag) - step_mag);
			y = y + ($urandom_range(0, 2 * step_mag) - step_mag);
			hd = hd + ($urandom_range(0, 2 * turn_mag) - turn_mag);
			send_waypoint(x, y, hd, 1'b0);
		end
	endtask

	// Waypoints with no earlier first point use the cleared history
	task automatic test_no_history();
		send_waypoint(32'sd6000, -32'sd3000, 32'sd500, 1'b0);
		send_waypoint(32'sd12000, -32'sd2000, -32'sd900, 1'b0);
		send_waypoint(32'sd12000, -32'sd2000, -32'sd900, 1'b0);
	endtask

	// Field extremes at the default settings
	task automatic test_field_extremes();
		send_waypoint(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
		send_waypoint(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
		send_waypoint(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
		send_waypoint(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
		send_waypoint(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
		send_waypoint(32'sh0, 32'sh0, 32'sh0, 1'b1);
		send_waypoint(32'sh0, 32'sh0, 32'sh1, 1'b0);
		send_waypoint(32'sh0, 32'sh0, 32'sh0, 1'b0);
		send_waypoint(32'sh1, 32'sh0, -32'sh1, 1'b0);
		send_waypoint(-32'sh3000, 32'sh2000, 32'sh1000, 1'b0);
		send_waypoint(32'sh55555555, 32'shaaaaaaaa, 32'sh5555aaaa, 1'b0);
		send_waypoint(32'shaaaaaaaa, 32'sh55555555, 32'shaaaa5555, 1'b1);
	endtask

	// Corner register settings, each followed by a short trajectory
	task automatic test_register_corners();
		// zero step time behaves as one LSB
		write_all(32'h0, 32'd183501, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		send_track(5, 3, 200);
		// slowest step, bit 31 of unsigned registers ignored
		write_all(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff);
		send_track(5, 1 << 28, 1 << 28);
		// zero speed limit forces a zero steering denominator
		write_all(32'd1638, 32'd183501, 32'h0, 32'h7fffffff,
			32'd131072, -32'sd131072, 32'h7fffffff, 32'h7fffffff);
		send_track(4, 5000, 4000);
		send_waypoint(32'sd10, 32'sd10, 32'sd10, 1'b0);
		send_waypoint(32'sd20, 32'sd20, 32'sd10, 1'b0);
		// all limits zero, crossed acceleration bounds
		write_all(32'd4096, 32'h0, 32'h0, 32'h0,
			-32'sd65536, 32'sd65536, 32'h0, 32'h0);
		send_track(4, 20000, 4000);
		// zero wheel base keeps steering at zero
		write_all(32'd1638, 32'h0, 32'd655360, 32'd45875,
			32'h80000000, 32'h7fffffff, 32'd32768, 32'd196608);
		send_track(4, 8000, 4000);
		// unknown indexes change nothing
		drain();
		for (int i = 8; i < 16; i++) write_register(4'(i), $urandom());
		send_track(3, 8000, 4000);
	endtask

	// Random settings and mostly well-formed trajectories
	task automatic test_random_trajectories();
		int r;
		while (points_sent < RANDOM_POINTS) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				write_all($urandom_range(200, 70000), $urandom_range(0, 400000),
					$urandom_range(0, 2000000), $urandom_range(0, 110000),
					$urandom_range(0, 600000), -$urandom_range(0, 600000),
					$urandom_range(0, 300000), $urandom_range(0, 900000));
			end else if (r < 8) begin
				write_all($urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom());
			end
			for (int t = 0; t < 6; t++) begin
				if ($urandom_range(0, 5) != 0) begin
					send_track($urandom_range(3, 14), $urandom_range(1, 60000),
						$urandom_range(0, 20000));
				end else begin
					repeat ($urandom_range(1, 8))
						send_waypoint($urandom(), $urandom(), $urandom(),
							1'($urandom_range(0, 1)));
				end
			end
		end
	endtask

	initial begin
		load_defaults();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_no_history();
		test_field_extremes();
		drain();
		test_register_corners();
		test_random_trajectories();
		drain();
		$display("Sent %0d waypoints, checked %0d results, %0d register writes.",
			points_sent, results_seen, config_writes);
		$display("Covered corner settings, field extremes and random trajectories.");
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
